@@ hw/rtl/mwsm_pkg.sv @@
`default_nettype none

package mwsm_pkg;

  localparam int unsigned SPD_W       = 9;
  localparam int unsigned HDG_W       = 16;
  localparam int unsigned DIFF_W      = 10;
  localparam int unsigned WHL_W       = 9;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 10;

  localparam int unsigned TBL_W  = 15;
  localparam int unsigned QBITS  = 10;
  localparam int unsigned REM_W  = 33;
  localparam int unsigned DEN_W  = 23;

  localparam int unsigned ST_S1   = 0;
  localparam int unsigned ST_S2   = 1;
  localparam int unsigned ST_S3   = 2;
  localparam int unsigned ST_S4   = 3;
  localparam int unsigned ST_DIV0 = 4;
  localparam int unsigned ST_FIN  = ST_DIV0 + QBITS + 1;
  localparam int unsigned ST_OUT  = ST_FIN + 1;
  localparam int unsigned NST     = ST_OUT + 1;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DRIVE_ENABLE = 2'd0,
    CFG_ROT_DIFF_MIN = 2'd1,
    CFG_ROT_DIFF_MAX = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef struct packed {
    logic                     en;
    logic signed [DIFF_W-1:0] d;
    logic [DEN_W-1:0]         den;
    logic                     neg_x;
    logic                     neg_y;
    logic [REM_W-1:0]         rem_x;
    logic [REM_W-1:0]         rem_y;
    logic [QBITS-1:0]         q_x;
    logic [QBITS-1:0]         q_y;
  } div_stage_t;

  // Sine of a Q30 angle in the first quadrant, scaled to 32767, from the
  // Taylor series through the thirteenth power.
  function automatic logic [TBL_W-1:0] sine_q15(input logic [63:0] x);
    logic [63:0]        t;
    logic signed [63:0] sum;
    logic [63:0]        r;
    t   = x;
    sum = $signed(x);
    t = (t * x) >> 30; t = (t * x) >> 30; t = t / 64'd6;   sum = sum - $signed(t);
    t = (t * x) >> 30; t = (t * x) >> 30; t = t / 64'd20;  sum = sum + $signed(t);
    t = (t * x) >> 30; t = (t * x) >> 30; t = t / 64'd42;  sum = sum - $signed(t);
    t = (t * x) >> 30; t = (t * x) >> 30; t = t / 64'd72;  sum = sum + $signed(t);
    t = (t * x) >> 30; t = (t * x) >> 30; t = t / 64'd110; sum = sum - $signed(t);
    t = (t * x) >> 30; t = (t * x) >> 30; t = t / 64'd156; sum = sum + $signed(t);
    if (sum < 0) begin
      sum = '0;
    end
    r = ($unsigned(sum) * 64'd32767 + 64'd536870912) >> 30;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[TBL_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/mecanum_wheel_speed_mixer.sv @@
// An accepted request reaches out_tvalid through 17 register stages (table
// read, two multiplies, a 10-stage divider).
// Throughput: one request per cycle; each stage holds under back-pressure.
// Reset (synchronous, rst_n low) empties the pipeline and sets drive_enable
// to 0, rot_diff_min to -510 and rot_diff_max to 510.
`default_nettype none

module mecanum_wheel_speed_mixer #(
  parameter int unsigned SINE_TABLE_DEPTH = 256
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // speed_fraction[8:0], heading_angle[24:9], rotation_diff[34:25], zero pad
  input  wire logic [mwsm_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // front_left[8:0], front_right[17:9], back_left[26:18], back_right[35:27]
  output logic [mwsm_pkg::OUT_TDATA_W-1:0]        out_tdata,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [mwsm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mwsm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import mwsm_pkg::*;

  localparam int unsigned IW      = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned IDX_M_W = 14 + IW;

  // Configuration registers.
  logic                     drive_enable_r;
  logic signed [DIFF_W-1:0] rot_diff_min_r;
  logic [8:0]               rot_diff_max_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_enable_r <= 1'b0;
      rot_diff_min_r <= -10'sd510;
      rot_diff_max_r <= 9'd510;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DRIVE_ENABLE: drive_enable_r <= cfg_data[0];
        CFG_ROT_DIFF_MIN: rot_diff_min_r <= $signed(cfg_data[DIFF_W-1:0]);
        CFG_ROT_DIFF_MAX: rot_diff_max_r <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Quarter-wave sine table, built at elaboration.
  logic [TBL_W-1:0] sin_tbl [0:SINE_TABLE_DEPTH];

  for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_tbl
    localparam logic [63:0] ANG = (64'(g) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
    assign sin_tbl[g] = sine_q15(ANG);
  end

  // Valid and ready chain.
  logic [NST-1:0] vld_r;
  logic [NST-1:0] vld_nxt;
  logic [NST-1:0] rdy;

  always_comb begin
    rdy[NST-1] = !vld_r[NST-1] || out_tready;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  always_comb begin
    for (int k = 0; k < NST; k++) begin
      if (k == 0) begin
        vld_nxt[k] = rdy[k] ? in_tvalid : vld_r[k];
      end else begin
        vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready = rdy[ST_S1];

  // Stage 1: clamp inputs, form quadrant and table indexes.
  logic [SPD_W-1:0]         spd_in;
  logic [HDG_W-1:0]         hdg_in;
  logic signed [DIFF_W-1:0] dif_in;
  logic [HDG_W-1:0]         ang;
  logic [IDX_M_W-1:0]       idx_full;
  logic                     below_min;
  logic signed [DIFF_W-1:0] d_nxt;
  logic [DIFF_W-1:0]        ad;

  logic                     s1_en_r;
  logic [SPD_W-1:0]         s1_spd_r, s1_spd_nxt;
  logic signed [DIFF_W-1:0] s1_d_r;
  logic signed [10:0]       s1_k_r, s1_k_nxt;
  quad_t                    s1_quad_r;
  logic [IW-1:0]            s1_idx_r, s1_idx_nxt;
  logic [IW-1:0]            s1_cidx_r, s1_cidx_nxt;

  assign spd_in = in_tdata[8:0];
  assign hdg_in = in_tdata[24:9];
  assign dif_in = $signed(in_tdata[34:25]);

  always_comb begin
    s1_spd_nxt = (spd_in > 9'd256) ? 9'd256 : spd_in;
    below_min  = dif_in < rot_diff_min_r;
    if (below_min) begin
      d_nxt = rot_diff_min_r;
    end else if ($signed({dif_in[DIFF_W-1], dif_in}) > $signed({2'b00, rot_diff_max_r})) begin
      d_nxt = $signed({1'b0, rot_diff_max_r});
    end else begin
      d_nxt = dif_in;
    end
    ad          = d_nxt[DIFF_W-1] ? DIFF_W'(-d_nxt) : DIFF_W'(d_nxt);
    s1_k_nxt    = 11'sd510 - $signed({1'b0, ad});
    ang         = hdg_in + 16'd8192;
    idx_full    = IDX_M_W'(ang[13:0]) * IDX_M_W'(SINE_TABLE_DEPTH);
    s1_idx_nxt  = idx_full[IDX_M_W-1:14];
    s1_cidx_nxt = IW'(SINE_TABLE_DEPTH) - s1_idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_S1]) begin
      s1_en_r   <= drive_enable_r;
      s1_spd_r  <= s1_spd_nxt;
      s1_d_r    <= d_nxt;
      s1_k_r    <= s1_k_nxt;
      s1_quad_r <= quad_t'(ang[15:14]);
      s1_idx_r  <= s1_idx_nxt;
      s1_cidx_r <= s1_cidx_nxt;
    end
  end

  // Stage 2: table reads.
  logic                     s2_en_r;
  logic [SPD_W-1:0]         s2_spd_r;
  logic signed [DIFF_W-1:0] s2_d_r;
  logic signed [10:0]       s2_k_r;
  quad_t                    s2_quad_r;
  logic [TBL_W-1:0]         s2_ti_r;
  logic [TBL_W-1:0]         s2_tc_r;

  always_ff @(posedge clk) begin
    if (rdy[ST_S2]) begin
      s2_en_r   <= s1_en_r;
      s2_spd_r  <= s1_spd_r;
      s2_d_r    <= s1_d_r;
      s2_k_r    <= s1_k_r;
      s2_quad_r <= s1_quad_r;
      s2_ti_r   <= sin_tbl[s1_idx_r];
      s2_tc_r   <= sin_tbl[s1_cidx_r];
    end
  end

  // Stage 3: quadrant select, peak magnitude, speed times rotation factor.
  logic signed [15:0]       ti_s, tc_s;
  logic signed [15:0]       s3_x0_nxt, s3_y0_nxt;
  logic [TBL_W-1:0]         s3_m_nxt;
  logic signed [20:0]       s3_sk_nxt;

  logic                     s3_en_r;
  logic signed [DIFF_W-1:0] s3_d_r;
  logic signed [15:0]       s3_x0_r, s3_y0_r;
  logic [TBL_W-1:0]         s3_m_r;
  logic signed [20:0]       s3_sk_r;

  always_comb begin
    ti_s = $signed({1'b0, s2_ti_r});
    tc_s = $signed({1'b0, s2_tc_r});
    case (s2_quad_r)
      QUAD_0: begin
        s3_x0_nxt = ti_s;
        s3_y0_nxt = tc_s;
      end
      QUAD_1: begin
        s3_x0_nxt = tc_s;
        s3_y0_nxt = -ti_s;
      end
      QUAD_2: begin
        s3_x0_nxt = -ti_s;
        s3_y0_nxt = -tc_s;
      end
      default: begin
        s3_x0_nxt = -tc_s;
        s3_y0_nxt = ti_s;
      end
    endcase
    s3_m_nxt = (s2_ti_r > s2_tc_r) ? s2_ti_r : s2_tc_r;
    if (s3_m_nxt == '0) begin
      s3_m_nxt = TBL_W'(1);
    end
    s3_sk_nxt = 21'($signed({1'b0, s2_spd_r})) * 21'(s2_k_r);
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_S3]) begin
      s3_en_r <= s2_en_r;
      s3_d_r  <= s2_d_r;
      s3_x0_r <= s3_x0_nxt;
      s3_y0_r <= s3_y0_nxt;
      s3_m_r  <= s3_m_nxt;
      s3_sk_r <= s3_sk_nxt;
    end
  end

  // Stage 4: scaled numerators.
  logic                     s4_en_r;
  logic signed [DIFF_W-1:0] s4_d_r;
  logic [TBL_W-1:0]         s4_m_r;
  logic signed [36:0]       s4_px_r, s4_py_r;

  always_ff @(posedge clk) begin
    if (rdy[ST_S4]) begin
      s4_en_r <= s3_en_r;
      s4_d_r  <= s3_d_r;
      s4_m_r  <= s3_m_r;
      s4_px_r <= 37'(s3_x0_r) * 37'(s3_sk_r);
      s4_py_r <= 37'(s3_y0_r) * 37'(s3_sk_r);
    end
  end

  // Stage 5 and divider: |P| / (256*m), one quotient bit per stage.
  div_stage_t        divs_r [0:QBITS];
  div_stage_t        div0_nxt;
  logic [36:0]       mag_x, mag_y;

  always_comb begin
    mag_x          = s4_px_r[36] ? $unsigned(-s4_px_r) : $unsigned(s4_px_r);
    mag_y          = s4_py_r[36] ? $unsigned(-s4_py_r) : $unsigned(s4_py_r);
    div0_nxt.en    = s4_en_r;
    div0_nxt.d     = s4_d_r;
    div0_nxt.den   = {s4_m_r, 8'd0};
    div0_nxt.neg_x = s4_px_r[36];
    div0_nxt.neg_y = s4_py_r[36];
    div0_nxt.rem_x = {1'b0, mag_x[31:0]};
    div0_nxt.rem_y = {1'b0, mag_y[31:0]};
    div0_nxt.q_x   = '0;
    div0_nxt.q_y   = '0;
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_DIV0]) begin
      divs_r[0] <= div0_nxt;
    end
  end

  for (genvar j = 0; j < QBITS; j++) begin : g_div
    localparam int unsigned B = QBITS - 1 - j;
    div_stage_t       step_nxt;
    logic [REM_W-1:0] sh;

    always_comb begin
      step_nxt = divs_r[j];
      sh       = REM_W'(divs_r[j].den) << B;
      if (divs_r[j].rem_x >= sh) begin
        step_nxt.rem_x  = divs_r[j].rem_x - sh;
        step_nxt.q_x[B] = 1'b1;
      end
      if (divs_r[j].rem_y >= sh) begin
        step_nxt.rem_y  = divs_r[j].rem_y - sh;
        step_nxt.q_y[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[ST_DIV0+j+1]) begin
        divs_r[j+1] <= step_nxt;
      end
    end
  end

  // Final stage: floor of the quotient and its exactness.
  div_stage_t         dq;
  logic [10:0]        fmag_x, fmag_y;
  logic signed [10:0] fin_fx_nxt, fin_fy_nxt;

  logic                     fin_en_r;
  logic signed [DIFF_W-1:0] fin_d_r;
  logic signed [10:0]       fin_fx_r, fin_fy_r;
  logic                     fin_ex_x_r, fin_ex_y_r;

  always_comb begin
    dq         = divs_r[QBITS];
    fmag_x     = {1'b0, dq.q_x} + 11'(dq.neg_x && (dq.rem_x != '0));
    fmag_y     = {1'b0, dq.q_y} + 11'(dq.neg_y && (dq.rem_y != '0));
    fin_fx_nxt = dq.neg_x ? -$signed(fmag_x) : $signed(fmag_x);
    fin_fy_nxt = dq.neg_y ? -$signed(fmag_y) : $signed(fmag_y);
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_FIN]) begin
      fin_en_r   <= dq.en;
      fin_d_r    <= dq.d;
      fin_fx_r   <= fin_fx_nxt;
      fin_fy_r   <= fin_fy_nxt;
      fin_ex_x_r <= (dq.rem_x == '0);
      fin_ex_y_r <= (dq.rem_y == '0);
    end
  end

  // Truncated half of (u + dd) with u known by its floor and exactness,
  // saturated to the wheel range.
  function automatic logic signed [WHL_W-1:0] half_sum(
    input logic signed [10:0] f,
    input logic               exact,
    input logic signed [10:0] dd
  );
    logic signed [11:0] w;
    logic signed [11:0] v;
    w = 12'(f) + 12'(dd);
    if (w < 0) begin
      v = (w + 12'sd1 + $signed({11'd0, ~exact})) >>> 1;
    end else begin
      v = w >>> 1;
    end
    if (v > 12'sd255) begin
      v = 12'sd255;
    end else if (v < -12'sd255) begin
      v = -12'sd255;
    end
    return v[WHL_W-1:0];
  endfunction

  // Output stage.
  logic signed [10:0]      dp, dn;
  logic signed [WHL_W-1:0] fl_nxt, fr_nxt, bl_nxt, br_nxt;
  logic [4*WHL_W-1:0]      out_r, out_nxt;

  always_comb begin
    dp     = 11'(fin_d_r);
    dn     = -dp;
    fl_nxt = -half_sum(fin_fx_r, fin_ex_x_r, dp);
    fr_nxt = half_sum(fin_fy_r, fin_ex_y_r, dn);
    bl_nxt = half_sum(fin_fy_r, fin_ex_y_r, dp);
    br_nxt = -half_sum(fin_fx_r, fin_ex_x_r, dn);
    if (fin_en_r) begin
      out_nxt = {br_nxt, bl_nxt, fr_nxt, fl_nxt};
    end else begin
      out_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_OUT]) begin
      out_r <= out_nxt;
    end
  end

  assign out_tvalid = vld_r[ST_OUT];
  assign out_tdata  = {(OUT_TDATA_W - 4 * WHL_W)'(0), out_r};

endmodule

`default_nettype wire

@@ tb/mwsm_wheel_checker.sv @@
module mwsm_wheel_checker
  import mwsm_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  input  wire logic                   in_tready,
  // speed_fraction[8:0], heading_angle[24:9], rotation_diff[34:25], zero pad
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                   out_tvalid,
  input  wire logic                   out_tready,
  // front_left[8:0], front_right[17:9], back_left[26:18], back_right[35:27]
  input  wire logic [OUT_TDATA_W-1:0] out_tdata,
  input  wire logic                   cfg_valid,
  input  wire logic                   cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output int                          mismatches,
  output int                          speeds_pending,
  output int                          speeds_checked
);

  typedef logic [3:0][WHL_W-1:0] wheel_set_t;

  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;

  longint     sine_lut [0:TABLE_DEPTH];
  logic       drive_en;
  longint     clamp_lo;
  longint     clamp_hi;
  wheel_set_t expected_speeds [$];
  string      wheel_label [4] = '{"front_left", "front_right", "back_left", "back_right"};

  // Quarter-wave sine entry in Q15, from a Q30 Taylor series through x^13.
  function automatic longint quarter_sine(input longint unsigned step);
    longint unsigned angle;
    longint unsigned term;
    longint unsigned scaled;
    longint          acc;
    angle = (step * QUARTER_TURN_Q30) / TABLE_DEPTH;
    term  = angle;
    acc   = angle;
    for (int k = 1; k <= 6; k++) begin
      term = (term * angle) >> 30;
      term = (term * angle) >> 30;
      term = term / longint'(2 * k * (2 * k + 1));
      acc  = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
    end
    if (acc < 0) begin
      acc = 0;
    end
    scaled = ($unsigned(acc) * 64'd32767 + 64'd536870912) >> 30;
    return (scaled > 64'd32767) ? 32767 : longint'(scaled);
  endfunction

  function automatic logic [WHL_W-1:0] clip_wheel(input longint num, input longint den);
    longint v;
    v = num / den;
    if (v > 255) begin
      v = 255;
    end else if (v < -255) begin
      v = -255;
    end
    return v[WHL_W-1:0];
  endfunction

  function automatic wheel_set_t mix_wheels(input logic [IN_TDATA_W-1:0] req);
    logic [SPD_W-1:0]         spd;
    logic [HDG_W-1:0]         ang;
    logic signed [DIFF_W-1:0] diff_raw;
    longint                   s, d, ad, ti, tc, x0, y0, m, xa, ya, hd, den;
    int unsigned              idx;
    wheel_set_t               ws;
    spd      = req[SPD_W-1:0];
    ang      = req[SPD_W +: HDG_W] + 16'd8192;
    diff_raw = req[SPD_W + HDG_W +: DIFF_W];
    if (!drive_en) begin
      return '0;
    end
    s = (spd > 9'd256) ? 256 : spd;
    d = diff_raw;
    if (d < clamp_lo) begin
      d = clamp_lo;
    end else if (d > clamp_hi) begin
      d = clamp_hi;
    end
    idx = (ang[13:0] * TABLE_DEPTH) >> 14;
    ti  = sine_lut[idx];
    tc  = sine_lut[TABLE_DEPTH - idx];
    case (quad_t'(ang[15:14]))
      QUAD_0: begin
        x0 = ti;
        y0 = tc;
      end
      QUAD_1: begin
        x0 = tc;
        y0 = -ti;
      end
      QUAD_2: begin
        x0 = -ti;
        y0 = -tc;
      end
      QUAD_3: begin
        x0 = -tc;
        y0 = ti;
      end
    endcase
    m = (x0 < 0) ? -x0 : x0;
    if (((y0 < 0) ? -y0 : y0) > m) begin
      m = (y0 < 0) ? -y0 : y0;
    end
    if (m == 0) begin
      m = 1;
    end
    ad  = (d < 0) ? -d : d;
    xa  = x0 * s * (510 - ad);
    ya  = y0 * s * (510 - ad);
    hd  = d * 256 * m;
    den = 512 * m;
    ws[0] = clip_wheel(-(xa + hd), den);
    ws[1] = clip_wheel(ya - hd, den);
    ws[2] = clip_wheel(ya + hd, den);
    ws[3] = clip_wheel(-(xa - hd), den);
    return ws;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 40) begin
      $display("mismatch: %s", msg);
    end
    mismatches++;
  endtask

  initial begin
    for (int i = 0; i <= TABLE_DEPTH; i++) begin
      sine_lut[i] = quarter_sine(i);
    end
  end

  always @(posedge clk) begin
    wheel_set_t got;
    wheel_set_t want;
    if (!rst_n) begin
      drive_en = 1'b0;
      clamp_lo = -510;
      clamp_hi = 510;
      expected_speeds.delete();
      mismatches     = 0;
      speeds_checked = 0;
      speeds_pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_DRIVE_ENABLE: drive_en = cfg_data[0];
          CFG_ROT_DIFF_MIN: clamp_lo = $signed(cfg_data);
          CFG_ROT_DIFF_MAX: clamp_hi = cfg_data[DIFF_W-2:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        expected_speeds.push_back(mix_wheels(in_tdata));
      end
      if (out_tvalid && out_tready) begin
        speeds_checked++;
        got = out_tdata[4*WHL_W-1:0];
        if (expected_speeds.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no request outstanding",
                                    speeds_checked));
        end else begin
          want = expected_speeds.pop_front();
          for (int k = 0; k < 4; k++) begin
            if (got[k] !== want[k]) begin
              report_mismatch($sformatf("result %0d, %s: expected %0d, got %0d",
                                        speeds_checked, wheel_label[k],
                                        $signed(want[k]), $signed(got[k])));
            end
          end
          if (out_tdata[OUT_TDATA_W-1:4*WHL_W] !== '0) begin
            report_mismatch($sformatf("result %0d: padding bits are not zero",
                                      speeds_checked));
          end
        end
      end
      speeds_pending <= expected_speeds.size();
    end
  end

endmodule

@@ tb/testbench.sv @@
module testbench;
  import mwsm_pkg::*;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 25;
  localparam int PAD_W        = IN_TDATA_W - SPD_W - HDG_W - DIFF_W;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  cfg_idx_t               cfg_index = CFG_DRIVE_ENABLE;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int hold_ack       = 0;
  int hold_cycles    = 0;
  int cycle_count    = 0;
  int requests_sent  = 0;
  int reg_writes     = 0;
  int mismatches;
  int speeds_pending;
  int speeds_checked;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mecanum_wheel_speed_mixer #(
    .SINE_TABLE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .*
  );

  mwsm_wheel_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_checker (
    .*
  );

  // A requested hold-off keeps the output stalled for a fixed stretch.
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack    <= hold_req;
      hold_cycles <= HOLD_CYCLES;
      out_tready  <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_tready  <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count, speeds_pending);
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
  endtask

  task automatic set_mode(input logic en, input logic [DIFF_W-1:0] lo,
                          input logic [DIFF_W-1:0] hi);
    write_reg(CFG_DRIVE_ENABLE, {{(CFG_DATA_W-1){1'b0}}, en});
    write_reg(CFG_ROT_DIFF_MIN, lo);
    write_reg(CFG_ROT_DIFF_MAX, hi);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_cmd(input logic [SPD_W-1:0] spd, input logic [HDG_W-1:0] hdg,
                          input logic [DIFF_W-1:0] diff);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{PAD_W{1'b0}}, diff, hdg, spd};
    do @(posedge clk); while (!in_tready);
    requests_sent++;
  endtask

  task automatic push_random_cmd();
    logic [SPD_W-1:0]  spd;
    logic [DIFF_W-1:0] diff;
    spd  = ($urandom_range(7) == 0) ? SPD_W'($urandom) : SPD_W'($urandom_range(256));
    diff = ($urandom_range(3) == 0) ? DIFF_W'($urandom)
                                    : DIFF_W'($urandom_range(1020) - 510);
    push_cmd(spd, HDG_W'($urandom), diff);
  endtask

  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (speeds_pending != 0);
  endtask

  task automatic run_random(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct <= stall_pct;
    repeat (count) push_random_cmd();
    wait_all_results();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Drive is off after reset, so these must come back as zeros.
    push_cmd(9'd256, 16'd0, 10'd0);
    push_cmd(9'd511, 16'd12000, 10'd300);
    push_cmd(9'd100, 16'd40000, DIFF_W'(-200));
    wait_all_results();

    // Enable only, so the reset clamp bounds stay in force.
    write_reg(CFG_DRIVE_ENABLE, {{(CFG_DATA_W-1){1'b0}}, 1'b1});
    cfg_valid <= 1'b0;
    push_cmd(9'd0, 16'd0, 10'd0);
    push_cmd(9'd256, 16'd0, 10'd0);
    push_cmd(9'd256, 16'd16384, 10'd0);
    push_cmd(9'd256, 16'd32768, 10'd0);
    push_cmd(9'd256, 16'd49152, 10'd0);
    push_cmd(9'd256, 16'd57344, 10'd0);
    push_cmd(9'd256, 16'd65535, 10'd0);
    push_cmd(9'd257, 16'd8192, 10'd0);
    push_cmd(9'd511, 16'd4096, DIFF_W'(-7));
    push_cmd(9'd256, 16'd0, 10'd510);
    push_cmd(9'd256, 16'd0, DIFF_W'(-510));
    push_cmd(9'd256, 16'd0, 10'd511);
    push_cmd(9'd256, 16'd0, DIFF_W'(-512));
    push_cmd(9'd128, 16'd12345, DIFF_W'(-1));
    push_cmd(9'd128, 16'd12345, 10'd1);
    push_cmd(9'd200, 16'd24576, DIFF_W'(-3));
    push_cmd(9'd0, 16'd40000, 10'd511);
    push_cmd(9'd511, 16'd65535, DIFF_W'(-512));
    push_cmd(9'd1, 16'd1, 10'd1);
    push_cmd(9'd255, 16'd8191, 10'd300);
    push_cmd(9'd256, 16'd60000, DIFF_W'(-300));
    wait_all_results();

    set_mode(1'b1, DIFF_W'(-512), 10'd511);
    run_random(130, 0, 0);
    set_mode(1'b1, DIFF_W'(-510), 10'd510);
    run_random(120, 78, 0);
    set_mode(1'b1, DIFF_W'(-100), 10'd250);
    run_random(120, 0, 78);
    // Crossed bounds: the lower bound is checked first and wins where it applies.
    set_mode(1'b1, 10'd200, 10'd50);
    run_random(80, 12, 12);
    set_mode(1'b1, 10'd0, 10'd0);
    hold_req <= hold_req + 1;
    run_random(80, 0, 0);
    set_mode(1'b0, DIFF_W'(-300), 10'd300);
    run_random(40, 12, 12);
    set_mode(1'b1, DIFF_W'(0 - int'($urandom_range(512))), DIFF_W'($urandom_range(511)));
    run_random(80, 0, 0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("coverage: %0d requests, %0d results checked, %0d register writes",
             requests_sent, speeds_checked, reg_writes);
    $display("coverage: drive on and off, clamp bounds wide, narrow and crossed, %s%0d",
             "idle and stall phases, output hold-off of ", HOLD_CYCLES);
    if (mismatches == 0 && speeds_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/mwsm_pkg.sv
hw/rtl/mecanum_wheel_speed_mixer.sv
tb/mwsm_wheel_checker.sv
tb/testbench.sv
